// File: design/prfs_pkg.sv
// prfs_pkg: shared types, character codes and decode functions for the
// printf format type scanner. No dependencies; used by every design file.
package prfs_pkg;

    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_Z       = 8'h7a;
    localparam logic [7:0] CH_J       = 8'h6a;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;

    localparam logic [7:0] MAX_ENTRIES_RESET = 8'd255;

    typedef enum logic [1:0] {
        KIND_INT32   = 2'd0,
        KIND_FLOAT64 = 2'd1,
        KIND_INT8    = 2'd2,
        KIND_OPAQUE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       ptr_level;
        logic [7:0] entry_index;
        logic       done_res;
        logic [7:0] total;
    } result_t;

    // Up to two results per request: a is first, b only follows a.
    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } scan_out_t;

    typedef struct packed {
        kind_t kind;
        logic  ptr_level;
    } spec_t;

    function automatic logic is_flag(input logic [7:0] c);
        is_flag = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
                  (c == CH_HASH) || (c == CH_STAR) || (c == CH_DOT) ||
                  ((c >= CH_0) && (c <= CH_9));
    endfunction

    function automatic spec_t classify(input logic [7:0] c);
        spec_t r;
        r.ptr_level = 1'b0;
        case (c)
            "d", "i", "o", "u", "x", "X", "c": r.kind = KIND_INT32;
            "f", "F", "e", "E", "g", "G", "a", "A": r.kind = KIND_FLOAT64;
            CH_S:
            begin
                r.kind      = KIND_INT8;
                r.ptr_level = 1'b1;
            end
            CH_N:
            begin
                r.kind      = KIND_INT32;
                r.ptr_level = 1'b1;
            end
            default: r.kind = KIND_OPAQUE;
        endcase
        classify = r;
    endfunction

endpackage

// File: design/prfs_scan.sv
// prfs_scan: scan phase and entry count state, decode of one format byte
// into zero, one or two results. Depends on prfs_pkg.
module prfs_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          ch,
    input  logic [7:0]          max_entries,
    output prfs_pkg::scan_out_t scan_out
);

    typedef enum logic [2:0] {
        PH_TEXT     = 3'd0,
        PH_PCT      = 3'd1,
        PH_FLAGS    = 3'd2,
        PH_LEN_L    = 3'd3,
        PH_LEN_H    = 3'd4,
        PH_LEN_DONE = 3'd5
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [7:0]      count_reg;
    logic [7:0]      count_next;
    logic            do_emit;
    logic            entry_valid;
    logic            done_valid;
    logic            below_limit;
    prfs_pkg::spec_t spec;
    prfs_pkg::result_t entry_res;
    prfs_pkg::result_t done_r;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        do_emit     = 1'b0;
        below_limit = count_reg < max_entries;
        spec        = prfs_pkg::classify(ch);

        if (ch == prfs_pkg::CH_END)
        begin
            do_emit = (phase_reg != PH_TEXT);
        end
        else
        begin
            case (phase_reg)
                PH_PCT, PH_FLAGS:
                begin
                    if (phase_reg == PH_PCT && ch == prfs_pkg::CH_PERCENT)
                        phase_next = PH_TEXT;
                    else if (prfs_pkg::is_flag(ch))
                        phase_next = PH_FLAGS;
                    else if (ch == prfs_pkg::CH_L)
                        phase_next = PH_LEN_L;
                    else if (ch == prfs_pkg::CH_H)
                        phase_next = PH_LEN_H;
                    else if (ch inside {prfs_pkg::CH_Z, prfs_pkg::CH_J, prfs_pkg::CH_T})
                        phase_next = PH_LEN_DONE;
                    else
                        do_emit = 1'b1;
                end
                PH_LEN_L:
                begin
                    if (ch == prfs_pkg::CH_L)
                        phase_next = PH_LEN_DONE;
                    else
                        do_emit = 1'b1;
                end
                PH_LEN_H:
                begin
                    if (ch == prfs_pkg::CH_H)
                        phase_next = PH_LEN_DONE;
                    else
                        do_emit = 1'b1;
                end
                PH_LEN_DONE: do_emit = 1'b1;
                default:
                begin
                    if (ch == prfs_pkg::CH_PERCENT && below_limit)
                        phase_next = PH_PCT;
                    else
                        phase_next = PH_TEXT;
                end
            endcase
        end

        entry_valid = do_emit && below_limit;
        if (do_emit)
            phase_next = PH_TEXT;
        if (entry_valid)
            count_next = count_reg + 8'd1;

        entry_res.kind        = spec.kind;
        entry_res.ptr_level   = spec.ptr_level;
        entry_res.entry_index = count_reg;
        entry_res.done_res    = 1'b0;
        entry_res.total       = 8'd0;

        done_valid           = (ch == prfs_pkg::CH_END);
        done_r.kind          = prfs_pkg::KIND_INT32;
        done_r.ptr_level     = 1'b0;
        done_r.entry_index   = 8'd0;
        done_r.done_res      = 1'b1;
        done_r.total         = count_next;

        if (done_valid)
        begin
            phase_next = PH_TEXT;
            count_next = 8'd0;
        end

        scan_out.a_valid = entry_valid || done_valid;
        scan_out.a       = entry_valid ? entry_res : done_r;
        scan_out.b_valid = entry_valid && done_valid;
        scan_out.b       = done_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            count_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.b_valid |-> scan_out.a_valid && scan_out.b.done_res)
        else $error("second result without first or not a done result");

    a_end_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && ch == prfs_pkg::CH_END |=> count_reg == 8'd0 && phase_reg == PH_TEXT)
        else $error("end of string did not restart the scan");

endmodule

// File: design/prfs_out.sv
// prfs_out: two-slot result buffer, an output register plus one held slot
// for the second result of a request. Depends on prfs_pkg.
module prfs_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  prfs_pkg::scan_out_t scan_out,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output prfs_pkg::result_t   out_res
);

    logic              out_valid_reg;
    prfs_pkg::result_t out_reg;
    logic              extra_valid_reg;
    prfs_pkg::result_t extra_reg;
    logic              taken;

    assign taken     = out_valid_reg && out_ready;
    assign room      = !extra_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            extra_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg   <= scan_out.a_valid;
            extra_valid_reg <= scan_out.b_valid;
        end
        else if (taken)
        begin
            out_valid_reg   <= extra_valid_reg;
            extra_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg   <= scan_out.a;
            extra_reg <= scan_out.b;
        end
        else if (taken && extra_valid_reg)
        begin
            out_reg <= extra_reg;
        end
    end

    a_extra_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg |-> out_valid_reg)
        else $error("held slot full while output register empty");

    a_extra_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg && out_ready |=> out_valid_reg && !extra_valid_reg)
        else $error("held result not moved to output register");

endmodule

// File: design/printf_format_type_scanner_unit.sv
// printf_format_type_scanner_unit: top level; input register, max_entries
// register, scanner and result buffer. Depends on prfs_pkg, prfs_scan, prfs_out.
// The unit takes one format byte per cycle and emits at most one result per cycle
// while out_ready holds and no second result is held. A byte waits in the input
// register and is decoded into the output register of the result buffer once the
// buffer has room. A byte that ends the string inside a conversion yields two
// results (entry, then done); the second is held in a spare slot and the input
// stalls while it drains. max_entries may be written only while
// the unit is idle.
module printf_format_type_scanner_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic       ptr_level,
    output logic [7:0] entry_index,
    output logic       done_res,
    output logic [7:0] total
);

    logic [7:0]          max_reg;
    logic                ch_valid_reg;
    logic [7:0]          ch_reg;
    logic                room;
    logic                advance;
    prfs_pkg::scan_out_t scan_out;
    prfs_pkg::result_t   out_res;

    assign cfg_ready = 1'b1;
    assign advance   = ch_valid_reg && room;
    assign in_ready  = !ch_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg      <= prfs_pkg::MAX_ENTRIES_RESET;
            ch_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_reg <= cfg_data;
            if (in_valid && in_ready)
                ch_valid_reg <= 1'b1;
            else if (advance)
                ch_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
    end

    prfs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .ch          (ch_reg),
        .max_entries (max_reg),
        .scan_out    (scan_out)
    );

    prfs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .scan_out  (scan_out),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind        = out_res.kind;
    assign ptr_level   = out_res.ptr_level;
    assign entry_index = out_res.entry_index;
    assign done_res    = out_res.done_res;
    assign total       = out_res.total;

endmodule
